/* design/cfpa_pkg.sv */
package cfpa_pkg;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	localparam int unsigned FIELD_W = 16;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [15:0] a_re;
		logic signed [15:0] a_im;
		logic signed [15:0] b_re;
		logic signed [15:0] b_im;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] res_re;
		logic signed [15:0] res_im;
		logic               div_zero;
		logic               sat_flag;
	} out_item_t;

endpackage

/* design/cfpa_mul.sv */
module cfpa_mul import cfpa_pkg::*; #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS  = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic [1:0]                     in_op,
	input  logic signed [DATA_WIDTH-1:0]   ar,
	input  logic signed [DATA_WIDTH-1:0]   ai,
	input  logic signed [DATA_WIDTH-1:0]   br,
	input  logic signed [DATA_WIDTH-1:0]   bi,
	output logic                           out_valid,
	output logic [1:0]                     out_op,
	output logic signed [2*DATA_WIDTH+1:0] num_re,
	output logic signed [2*DATA_WIDTH+1:0] num_im,
	output logic [2*DATA_WIDTH:0]          den,
	output logic                           zero_div
);
	// Stage 1: four cross products, two squares and the add/sub sums; stage 2: combine sums.
	localparam int PW = 2 * DATA_WIDTH;
	localparam int SW = 2 * DATA_WIDTH + 2;

	logic                  v_s1;
	logic [1:0]            op_s1;
	logic signed [PW-1:0]  rr_s1, ii_s1, ri_s1, ir_s1, bb_s1, cc_s1;
	logic signed [DATA_WIDTH:0] sre_s1, sim_s1;
	logic                  z_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= in_op;
		rr_s1 <= ar * br;
		ii_s1 <= ai * bi;
		ri_s1 <= ar * bi;
		ir_s1 <= ai * br;
		bb_s1 <= br * br;
		cc_s1 <= bi * bi;
		z_s1  <= (br == '0) && (bi == '0);
		if (in_op == OP_ADD) begin
			sre_s1 <= {ar[DATA_WIDTH-1], ar} + {br[DATA_WIDTH-1], br};
			sim_s1 <= {ai[DATA_WIDTH-1], ai} + {bi[DATA_WIDTH-1], bi};
		end else begin
			sre_s1 <= {ar[DATA_WIDTH-1], ar} - {br[DATA_WIDTH-1], br};
			sim_s1 <= {ai[DATA_WIDTH-1], ai} - {bi[DATA_WIDTH-1], bi};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		out_op   <= op_s1;
		zero_div <= z_s1;
		den      <= {1'b0, bb_s1} + {1'b0, cc_s1};
		unique case (op_t'(op_s1))
			OP_ADD, OP_SUB: begin
				// add/sub results carry FRAC_BITS extra zeros so the later shift restores them
				num_re <= SW'(sre_s1) <<< FRAC_BITS;
				num_im <= SW'(sim_s1) <<< FRAC_BITS;
			end
			OP_MUL: begin
				num_re <= SW'(rr_s1) - SW'(ii_s1);
				num_im <= SW'(ri_s1) + SW'(ir_s1);
			end
			default: begin
				num_re <= SW'(rr_s1) + SW'(ii_s1);
				num_im <= SW'(ir_s1) - SW'(ri_s1);
			end
		endcase
	end
endmodule

/* design/cfpa_div.sv */
module cfpa_div import cfpa_pkg::*; #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS  = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic [1:0]                     in_op,
	input  logic signed [2*DATA_WIDTH+1:0] num_re,
	input  logic signed [2*DATA_WIDTH+1:0] num_im,
	input  logic [2*DATA_WIDTH:0]          den,
	input  logic                           zero_div,
	output logic                           out_valid,
	output out_item_t                      out_item
);
	// Magnitudes are truncated; sign applied last. For add/sub/mul the
	// divider is bypassed: magnitude >> FRAC_BITS. Divide is restoring,
	// one quotient bit per stage, QB stages.
	localparam int SW = 2 * DATA_WIDTH + 2;
	localparam int MW = SW + FRAC_BITS;         // scaled numerator width
	localparam int QB = DATA_WIDTH + 1;         // enough to exceed the clip limit
	localparam int DW = 2 * DATA_WIDTH + 1;
	localparam int XW = DW + QB;                // divisor shifted by the top quotient bit
	localparam int NS = QB + 1;
	localparam logic [MW-1:0] LIM = MW'(1) << (DATA_WIDTH - 1);

	// Quotient bits from bit QB up are folded into a sticky overflow per part.
	logic           v_p  [NS];
	logic [1:0]     op_p [NS];
	logic           z_p  [NS];
	logic [DW-1:0]  d_p  [NS];
	logic           ng_p [NS][2];
	logic [MW-1:0]  r_p  [NS][2];   // partial remainder / dividend
	logic [QB-1:0]  q_p  [NS][2];
	logic           ov_p [NS][2];

	function automatic logic [MW-1:0] mag_of(input logic signed [SW-1:0] v);
		logic [SW-1:0] m;
		m = v[SW-1] ? SW'(-v) : SW'(v);
		return MW'(m);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p[0] <= 1'b0;
		end else begin
			v_p[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		logic [MW-1:0] mr, mi;
		mr = mag_of(num_re);
		mi = mag_of(num_im);
		op_p[0] <= in_op;
		z_p[0]  <= zero_div;
		d_p[0]  <= den;
		ng_p[0][0] <= num_re[SW-1];
		ng_p[0][1] <= num_im[SW-1];
		if (op_t'(in_op) == OP_DIV) begin
			r_p[0][0] <= mr << FRAC_BITS;
			r_p[0][1] <= mi << FRAC_BITS;
		end else begin
			r_p[0][0] <= mr >> FRAC_BITS;
			r_p[0][1] <= mi >> FRAC_BITS;
		end
		q_p[0][0]  <= '0;
		q_p[0][1]  <= '0;
		ov_p[0][0] <= 1'b0;
		ov_p[0][1] <= 1'b0;
	end

	for (genvar s = 1; s < NS; s++) begin : g_stage
		localparam int B = QB - s;   // quotient bit weight handled here
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_p[s] <= 1'b0;
			end else begin
				v_p[s] <= v_p[s-1];
			end
		end
		always_ff @(posedge clk) begin
			logic [XW-1:0] sh;
			logic [MW-1:0] rn;
			logic [QB-1:0] qn;
			logic          ovn;
			op_p[s] <= op_p[s-1];
			z_p[s]  <= z_p[s-1];
			d_p[s]  <= d_p[s-1];
			sh = XW'(d_p[s-1]) << B;
			for (int k = 0; k < 2; k++) begin
				rn  = r_p[s-1][k];
				qn  = q_p[s-1][k];
				ovn = ov_p[s-1][k];
				if (op_t'(op_p[s-1]) == OP_DIV && d_p[s-1] != '0) begin
					if (s == 1) begin
						// anything at or above 2^QB times den is overflow
						if ((r_p[s-1][k] >> QB) >= MW'(d_p[s-1])) begin
							ovn = 1'b1;
						end
					end
					if (!ov_p[s-1][k] && XW'(r_p[s-1][k]) >= sh) begin
						rn    = MW'(XW'(r_p[s-1][k]) - sh);
						qn[B] = 1'b1;
					end
				end
				ng_p[s][k] <= ng_p[s-1][k];
				q_p[s][k]  <= qn;
				r_p[s][k]  <= rn;
				ov_p[s][k] <= ovn;
			end
		end
	end

	// Final stage: pick magnitude, saturate, apply sign, or flag a divide by zero.
	logic [MW-1:0] mag [2];
	logic          ovr [2];
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			if (op_t'(op_p[NS-1]) == OP_DIV) begin
				mag[k] = MW'(q_p[NS-1][k]);
				ovr[k] = ov_p[NS-1][k];
			end else begin
				mag[k] = r_p[NS-1][k];
				ovr[k] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_p[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		logic [DATA_WIDTH-1:0] res [2];
		logic                  sat;
		sat = 1'b0;
		for (int k = 0; k < 2; k++) begin
			if (!ng_p[NS-1][k] || mag[k] == '0) begin
				if (ovr[k] || mag[k] > LIM - MW'(1)) begin
					res[k] = DATA_WIDTH'(LIM - MW'(1));
					sat    = 1'b1;
				end else begin
					res[k] = DATA_WIDTH'(mag[k]);
				end
			end else begin
				if (ovr[k] || mag[k] > LIM) begin
					res[k] = DATA_WIDTH'(LIM);
					sat    = 1'b1;
				end else begin
					res[k] = DATA_WIDTH'(-mag[k]);
				end
			end
		end
		if (op_t'(op_p[NS-1]) == OP_DIV && z_p[NS-1]) begin
			out_item.res_re   <= '0;
			out_item.res_im   <= '0;
			out_item.div_zero <= 1'b1;
			out_item.sat_flag <= 1'b0;
		end else begin
			out_item.res_re   <= FIELD_W'(signed'(res[0]));
			out_item.res_im   <= FIELD_W'(signed'(res[1]));
			out_item.div_zero <= 1'b0;
			out_item.sat_flag <= sat;
		end
	end
endmodule

/* design/complex_fixed_point_alu_top.sv */
// Complex add, subtract, multiply and divide on signed 16-bit fixed point
// operands (FRAC_BITS fractional). Pulse start with the operand beat; busy is
// never asserted, so a beat can enter every cycle. Each result shows on result
// for exactly one cycle with done high, after passing two multiply stages, 18
// divide stages and one output stage; all operations pass the same stages so
// results leave in order. The receiver must take each result when done is high.
module complex_fixed_point_alu_top import cfpa_pkg::*; #(
	parameter int FRAC_BITS  = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  in_item_t  operands,
	output logic      busy,
	output logic      done,
	output out_item_t result
);
	logic                        m_valid;
	logic [1:0]                  m_op;
	logic signed [2*FIELD_W+1:0] m_re, m_im;
	logic [2*FIELD_W:0]          m_den;
	logic                        m_zero;

	assign busy = 1'b0;

	cfpa_mul #(.DATA_WIDTH(FIELD_W), .FRAC_BITS(FRAC_BITS)) u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start),
		.in_op    (operands.op),
		.ar       (FIELD_W'(operands.a_re)),
		.ai       (FIELD_W'(operands.a_im)),
		.br       (FIELD_W'(operands.b_re)),
		.bi       (FIELD_W'(operands.b_im)),
		.out_valid(m_valid),
		.out_op   (m_op),
		.num_re   (m_re),
		.num_im   (m_im),
		.den      (m_den),
		.zero_div (m_zero)
	);

	cfpa_div #(.DATA_WIDTH(FIELD_W), .FRAC_BITS(FRAC_BITS)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (m_valid),
		.in_op    (m_op),
		.num_re   (m_re),
		.num_im   (m_im),
		.den      (m_den),
		.zero_div (m_zero),
		.out_valid(done),
		.out_item (result)
	);
endmodule

/* test/complex_fixed_point_alu_top_test.sv */
`timescale 1ns / 1ps

module complex_fixed_point_alu_top_test;
	import cfpa_pkg::*;

	localparam int LATENCY   = FIELD_W + 6;
	localparam int N_RANDOM  = 1750;
	localparam int MAX_CYCLES = 200000;
	localparam logic signed [15:0] MAXV = 16'sh7fff;
	localparam logic signed [15:0] MINV = -16'sh8000;

	typedef struct {
		in_item_t  beat;
		bit        typed;
		out_item_t want;
	} row_t;

	logic      clk;
	logic      arst_n;
	logic      start;
	in_item_t  operands;
	logic      busy;
	logic      done;
	out_item_t result;

	out_item_t pending_results[$];
	row_t      rows[$];
	int        mismatches;
	int        cycles;
	int        checked;
	int        div_zero_seen;
	int        sat_seen;

	complex_fixed_point_alu_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.operands (operands),
		.busy     (busy),
		.done     (done),
		.result   (result)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Clip a wide value to the 16-bit signed range.
	function automatic logic [15:0] clip(input logic signed [63:0] v, inout bit sat);
		if (v > 64'sd32767) begin
			sat = 1;
			return MAXV;
		end
		if (v < -64'sd32768) begin
			sat = 1;
			return MINV;
		end
		return v[15:0];
	endfunction

	// Truncate toward zero: shift the magnitude, then reapply the sign.
	function automatic logic signed [63:0] trunc_shift(input logic signed [63:0] v);
		logic signed [63:0] m;
		m = (v < 0) ? -v : v;
		m = m >>> 8;
		return (v < 0) ? -m : m;
	endfunction

	function automatic logic signed [63:0] trunc_div(input logic signed [63:0] num,
			input logic signed [63:0] den);
		logic signed [63:0] m;
		m = (num < 0) ? -num : num;
		m = (m <<< 8) / den;
		return (num < 0) ? -m : m;
	endfunction

	function automatic out_item_t complex_result(input in_item_t x);
		out_item_t r;
		logic signed [63:0] ar, ai, br, bi, re, im, den;
		bit sat;
		ar = x.a_re;
		ai = x.a_im;
		br = x.b_re;
		bi = x.b_im;
		sat = 0;
		r = '0;
		case (op_t'(x.op))
			OP_ADD: begin
				re = ar + br;
				im = ai + bi;
			end
			OP_SUB: begin
				re = ar - br;
				im = ai - bi;
			end
			OP_MUL: begin
				re = trunc_shift(ar * br - ai * bi);
				im = trunc_shift(ar * bi + br * ai);
			end
			default: begin
				if (br == 0 && bi == 0) begin
					r.div_zero = 1'b1;
					return r;
				end
				den = br * br + bi * bi;
				re = trunc_div(ar * br + ai * bi, den);
				im = trunc_div(ai * br - ar * bi, den);
			end
		endcase
		r.res_re = clip(re, sat);
		r.res_im = clip(im, sat);
		r.sat_flag = sat;
		return r;
	endfunction

	function automatic in_item_t mk(input op_t o, input logic [15:0] ar, input logic [15:0] ai,
			input logic [15:0] br, input logic [15:0] bi);
		in_item_t x;
		x.op = o;
		x.a_re = ar;
		x.a_im = ai;
		x.b_re = br;
		x.b_im = bi;
		return x;
	endfunction

	function automatic out_item_t res(input logic [15:0] re, input logic [15:0] im,
			input logic dz, input logic sf);
		out_item_t r;
		r.res_re = re;
		r.res_im = im;
		r.div_zero = dz;
		r.sat_flag = sf;
		return r;
	endfunction

	task automatic add_row(input in_item_t x, input bit typed, input out_item_t want);
		row_t r;
		r.beat = x;
		r.typed = typed;
		r.want = want;
		rows.push_back(r);
	endtask

	task automatic build_table();
		out_item_t none;
		none = '0;
		add_row(mk(OP_ADD, 16'h0100, 16'h0200, 16'h0100, 16'hff00), 1, res(16'h0200, 16'h0100, 0, 0));
		add_row(mk(OP_ADD, MAXV, MINV, 16'h0001, 16'hffff), 1, res(MAXV, MINV, 0, 1));
		add_row(mk(OP_ADD, MINV, MAXV, MINV, MAXV), 1, res(MINV, MAXV, 0, 1));
		add_row(mk(OP_SUB, MINV, MAXV, 16'h0001, 16'hffff), 1, res(MINV, MAXV, 0, 1));
		add_row(mk(OP_SUB, MAXV, MAXV, MAXV, MAXV), 1, res(16'h0000, 16'h0000, 0, 0));
		add_row(mk(OP_SUB, 16'h0000, 16'h0000, MINV, MINV), 1, res(MAXV, MAXV, 0, 1));
		add_row(mk(OP_MUL, 16'h0100, 16'h0000, 16'h0100, 16'h0000), 1, res(16'h0100, 16'h0000, 0, 0));
		add_row(mk(OP_MUL, 16'h0000, 16'h0100, 16'h0000, 16'h0100), 1, res(16'hff00, 16'h0000, 0, 0));
		add_row(mk(OP_MUL, MAXV, MAXV, MAXV, MAXV), 0, none);
		add_row(mk(OP_MUL, MINV, MINV, MINV, MINV), 0, none);
		add_row(mk(OP_MUL, 16'hffff, 16'h0000, 16'h0001, 16'h0000), 0, none);
		add_row(mk(OP_MUL, MINV, MAXV, MAXV, MINV), 0, none);
		add_row(mk(OP_DIV, 16'h1234, 16'h5678, 16'h0000, 16'h0000), 1, res(16'h0000, 16'h0000, 1, 0));
		add_row(mk(OP_DIV, MAXV, MINV, 16'h0000, 16'h0000), 1, res(16'h0000, 16'h0000, 1, 0));
		add_row(mk(OP_DIV, 16'h0100, 16'h0000, 16'h0100, 16'h0000), 1, res(16'h0100, 16'h0000, 0, 0));
		add_row(mk(OP_DIV, MAXV, MAXV, 16'h0001, 16'h0000), 1, res(MAXV, MAXV, 0, 1));
		add_row(mk(OP_DIV, MINV, MINV, 16'h0001, 16'h0000), 1, res(MINV, MINV, 0, 1));
		add_row(mk(OP_DIV, MINV, MAXV, MINV, MINV), 0, none);
		add_row(mk(OP_DIV, 16'hffff, 16'h0001, MAXV, MAXV), 0, none);
		add_row(mk(OP_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0001), 0, none);
		add_row(mk(OP_DIV, 16'h0300, 16'hfd00, 16'h0000, 16'hffff), 0, none);
	endtask

	function automatic logic [15:0] rand_field();
		case ($urandom_range(0, 5))
			0: return MAXV;
			1: return MINV;
			2: return 16'($signed($urandom_range(0, 1024)) - 512);
			3: return 16'($urandom_range(0, 3));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send(input in_item_t x);
		operands <= x;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Track expectations at each accepted beat.
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			pending_results.push_back(complex_result(operands));
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", result);
			end else begin
				want = pending_results.pop_front();
				checked++;
				if (result.div_zero)
					div_zero_seen++;
				if (result.sat_flag)
					sat_seen++;
				if (result.res_re !== want.res_re || result.res_im !== want.res_im ||
						result.div_zero !== want.div_zero ||
						result.sat_flag !== want.sat_flag) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected re %h im %h dz %b sat %b, got re %h im %h dz %b sat %b",
							want.res_re, want.res_im, want.div_zero, want.sat_flag,
							result.res_re, result.res_im, result.div_zero, result.sat_flag);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		in_item_t x;
		out_item_t want;
		int idle_pct;
		arst_n = 1'b0;
		start = 1'b0;
		operands = '0;
		mismatches = 0;
		cycles = 0;
		checked = 0;
		div_zero_seen = 0;
		sat_seen = 0;
		build_table();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].typed) begin
				want = complex_result(rows[i].beat);
				if (want != rows[i].want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("table row %0d: expected %h, predictor %h", i, rows[i].want, want);
				end
			end
			send(rows[i].beat);
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			// Run back to back through the middle stretch.
			idle_pct = (n >= 600 && n < 900) ? 0 : 10;
			if ($urandom_range(1, 100) <= idle_pct) begin
				start <= 1'b0;
				operands <= '0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			x.op = 2'($urandom);
			x.a_re = rand_field();
			x.a_im = rand_field();
			if ($urandom_range(0, 9) == 0) begin
				x.b_re = 0;
				x.b_im = 0;
			end else begin
				x.b_re = rand_field();
				x.b_im = rand_field();
			end
			send(x);
		end
		start <= 1'b0;
		operands <= '0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);

		$display("checked %0d results of %0d table rows and %0d random beats",
			checked, rows.size(), N_RANDOM);
		$display("divide-by-zero results: %0d, saturated results: %0d, mismatches: %0d",
			div_zero_seen, sat_seen, mismatches);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

/* complex_fixed_point_alu_top.f */
design/cfpa_pkg.sv
design/cfpa_mul.sv
design/cfpa_div.sv
design/complex_fixed_point_alu_top.sv
test/complex_fixed_point_alu_top_test.sv
